/* hw/rtl/content_type_header_parser_assert.svh */
// assertion macros shared by the parser rtl
`ifndef CONTENT_TYPE_HEADER_PARSER_ASSERT_SVH
`define CONTENT_TYPE_HEADER_PARSER_ASSERT_SVH

// same-cycle implication
`define CTHP_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("parser assertion failed");

// next-cycle implication
`define CTHP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("parser assertion failed");

`endif

/* hw/rtl/ctph_pkg.sv */
package ctph_pkg;

   localparam int VALUE_DEPTH = 128;
   localparam int VD_AW = $clog2(VALUE_DEPTH);
   localparam int LEN_W = VD_AW + 1;
   localparam int IDX_W = 7;
   localparam int CMP_W = (LEN_W > IDX_W) ? LEN_W : IDX_W;
   localparam int CNT_W = 8;

   localparam int TYPE_N = 6;
   localparam int KEY_N = 2;
   localparam int TYPE_POS_W = 6;
   localparam int KEY_POS_W = 4;
   localparam logic [TYPE_POS_W-1:0] TYPE_POS_CAP = 6'd63;
   localparam logic [KEY_POS_W-1:0] KEY_POS_CAP = 4'd15;

   localparam logic [7:0] CH_SEMI = 8'h3B;
   localparam logic [7:0] CH_EQUAL = 8'h3D;

   typedef enum logic [1:0] {
      MODE_HEADER        = 2'd0,
      MODE_READ_CHARSET  = 2'd1,
      MODE_READ_BOUNDARY = 2'd2
   } mode_type;

   typedef enum logic [1:0] {
      PH_TYPE  = 2'd0,
      PH_KEY   = 2'd1,
      PH_VALUE = 2'd2,
      PH_STOP  = 2'd3
   } phase_type;

   typedef enum logic [1:0] {
      TGT_NONE     = 2'd0,
      TGT_CHARSET  = 2'd1,
      TGT_BOUNDARY = 2'd2
   } target_type;

   typedef enum logic [2:0] {
      TC_UNKNOWN    = 3'd0,
      TC_JSON       = 3'd1,
      TC_FORM       = 3'd2,
      TC_MULTIPART  = 3'd3,
      TC_TEXT_PLAIN = 3'd4,
      TC_APP_XML    = 3'd5,
      TC_TEXT_XML   = 3'd6
   } type_code_type;

   // literals left aligned, zero padded to the longest one
   localparam int LIT_MAX = 33;
   localparam int LIT_W = 8 * LIT_MAX;

   localparam logic [LIT_W-1:0] TYPE_LIT [TYPE_N] = '{
      {"application/json", 136'h0},
      "application/x-www-form-urlencoded",
      {"multipart/form-data", 112'h0},
      {"text/plain", 184'h0},
      {"application/xml", 144'h0},
      {"text/xml", 200'h0}
   };
   localparam logic [TYPE_POS_W-1:0] TYPE_LEN [TYPE_N] = '{
      6'd16, 6'd33, 6'd19, 6'd10, 6'd15, 6'd8
   };

   localparam logic [LIT_W-1:0] KEY_LIT [KEY_N] = '{
      {"charset", 208'h0},
      {"boundary", 200'h0}
   };
   localparam logic [TYPE_POS_W-1:0] KEY_LEN [KEY_N] = '{6'd7, 6'd8};

   function automatic logic is_blank(logic [7:0] c);
      return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
   endfunction

   function automatic logic [7:0] lower_ascii(logic [7:0] c);
      return (c >= 8'h41 && c <= 8'h5A) ? c + 8'h20 : c;
   endfunction

   function automatic logic lit_match(logic [LIT_W-1:0] lit, logic [TYPE_POS_W-1:0] len,
                                      logic [TYPE_POS_W-1:0] pos, logic [7:0] c);
      logic [LIT_W-1:0] sh;
      sh = lit << {pos, 3'b000};
      return (pos < len) && (sh[LIT_W-1 -: 8] == c);
   endfunction

   // first known type whose literal matched completely
   function automatic type_code_type type_class(logic [TYPE_N-1:0] mask,
                                                logic [TYPE_POS_W-1:0] pos);
      type_code_type r;
      r = TC_UNKNOWN;
      for (int i = TYPE_N - 1; i >= 0; i--) begin
         if (mask[i] && pos == TYPE_LEN[i]) begin
            r = type_code_type'(3'(i + 1));
         end
      end
      return r;
   endfunction

endpackage

/* hw/rtl/ctph_channels.sv */
interface ctph_req_if;
   logic                       valid;
   logic                       ready;
   logic [1:0]                 mode;
   logic [7:0]                 data_byte;
   logic [ctph_pkg::IDX_W-1:0] read_index;
   logic                       last;

   modport source (output valid, mode, data_byte, read_index, last, input ready);
   modport sink (input valid, mode, data_byte, read_index, last, output ready);
endinterface

interface ctph_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [7:0]                 read_byte;
   logic [2:0]                 type_code;
   logic [ctph_pkg::CNT_W-1:0] charset_count;
   logic [ctph_pkg::CNT_W-1:0] boundary_count;
   logic                       value_truncated;
   logic                       header_done;

   modport source (output valid, read_byte, type_code, charset_count, boundary_count,
                   value_truncated, header_done, input ready);
   modport sink (input valid, read_byte, type_code, charset_count, boundary_count,
                 value_truncated, header_done, output ready);
endinterface

/* hw/rtl/ctph_ram.sv */
module ctph_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* hw/rtl/content_type_header_parser.sv */
// Content-Type header parser. Takes one word per clock on req_bus, back to back, and gives
// exactly one result word per input word on rsp_bus, in the cycle after the word is accepted;
// req_bus.ready is high whenever the result register is empty or being taken in the same
// cycle, so a steady stream runs at one byte per clock. Header bytes (mode 0) update the
// parse state, and those of a charset or boundary value go into its RAM in the cycle they are
// accepted; read words (modes 1 and 2) fetch through the RAM's registered read port, so the
// read data lands together with the result register. The value RAMs are never cleared:
// reads at or past the stored length return zero, and no clearing pass follows reset.
`include "content_type_header_parser_assert.svh"

module content_type_header_parser (
   input logic         clock,
   input logic         reset,
   ctph_req_if.sink    req_bus,
   ctph_rsp_if.source  rsp_bus
);

   localparam logic [ctph_pkg::LEN_W-1:0] DEPTH_LEN = ctph_pkg::LEN_W'(ctph_pkg::VALUE_DEPTH);
   localparam logic [ctph_pkg::CMP_W-1:0] DEPTH_CMP = ctph_pkg::CMP_W'(ctph_pkg::VALUE_DEPTH);

   // parse state
   ctph_pkg::phase_type                    phase_ff, phase_in;
   logic [ctph_pkg::TYPE_N-1:0]            tmask_ff, tmask_in;
   logic [ctph_pkg::TYPE_POS_W-1:0]        tpos_ff, tpos_in;
   logic                                   tgap_ff, tgap_in;
   logic [ctph_pkg::KEY_N-1:0]             kmask_ff, kmask_in;
   logic [ctph_pkg::KEY_POS_W-1:0]         kpos_ff, kpos_in;
   logic                                   kgap_ff, kgap_in;
   ctph_pkg::target_type                   target_ff, target_in;
   logic [ctph_pkg::LEN_W-1:0]             wp_ff, wp_in;
   logic [ctph_pkg::LEN_W-1:0]             cs_len_ff, cs_len_in;
   logic [ctph_pkg::LEN_W-1:0]             bd_len_ff, bd_len_in;
   logic                                   trunc_ff, trunc_in;
   logic                                   hstart_ff, hstart_in;

   // result register
   logic                                   rsp_valid_ff, rsp_valid_in;
   ctph_pkg::target_type                   rd_sel_ff, rd_sel_in;
   ctph_pkg::type_code_type                type_code_ff, type_code_in;
   logic                                   done_ff, done_in;

   logic                                   req_fire;
   ctph_pkg::mode_type                     mode;
   logic [7:0]                             c, lc;
   logic                                   blank;
   logic [ctph_pkg::CMP_W-1:0]             idx_cmp;
   logic                                   cs_wr_en, bd_wr_en, cs_rd_en, bd_rd_en;
   logic [ctph_pkg::VD_AW-1:0]             wr_addr, rd_addr;
   logic [7:0]                             wr_data;
   logic [7:0]                             cs_q, bd_q;
   logic                                   in_stop;

   assign req_bus.ready = !rsp_valid_ff || rsp_bus.ready;
   assign req_fire      = req_bus.valid && req_bus.ready;
   assign mode          = ctph_pkg::mode_type'(req_bus.mode);
   assign c             = req_bus.data_byte;
   assign lc            = ctph_pkg::lower_ascii(c);
   assign blank         = ctph_pkg::is_blank(c);
   assign idx_cmp       = ctph_pkg::CMP_W'(req_bus.read_index);
   assign rd_addr       = ctph_pkg::VD_AW'(req_bus.read_index);

   always_comb begin
      phase_in  = phase_ff;
      tmask_in  = tmask_ff;
      tpos_in   = tpos_ff;
      tgap_in   = tgap_ff;
      kmask_in  = kmask_ff;
      kpos_in   = kpos_ff;
      kgap_in   = kgap_ff;
      target_in = target_ff;
      wp_in     = wp_ff;
      cs_len_in = cs_len_ff;
      bd_len_in = bd_len_ff;
      trunc_in  = trunc_ff;
      hstart_in = hstart_ff;
      cs_wr_en  = 1'b0;
      bd_wr_en  = 1'b0;
      cs_rd_en  = 1'b0;
      bd_rd_en  = 1'b0;
      wr_addr   = ctph_pkg::VD_AW'(wp_ff);
      wr_data   = c;
      rd_sel_in = ctph_pkg::TGT_NONE;
      done_in   = 1'b0;

      if (req_fire) begin
         unique case (mode)
            ctph_pkg::MODE_HEADER: begin
               if (hstart_ff) begin
                  phase_in  = ctph_pkg::PH_TYPE;
                  tmask_in  = '1;
                  tpos_in   = '0;
                  tgap_in   = 1'b0;
                  kmask_in  = '1;
                  kpos_in   = '0;
                  kgap_in   = 1'b0;
                  target_in = ctph_pkg::TGT_NONE;
                  wp_in     = '0;
                  cs_len_in = '0;
                  bd_len_in = '0;
                  trunc_in  = 1'b0;
               end
               hstart_in = req_bus.last;
               done_in   = req_bus.last;

               unique case (phase_in)
                  ctph_pkg::PH_TYPE: begin
                     if (c == ctph_pkg::CH_SEMI) begin
                        phase_in = ctph_pkg::PH_KEY;
                        kmask_in = '1;
                        kpos_in  = '0;
                        kgap_in  = 1'b0;
                     end else if (blank) begin
                        if (tpos_in != '0) begin
                           tgap_in = 1'b1;
                        end
                     end else begin
                        // blank inside the type kills every candidate
                        if (tgap_in) begin
                           tmask_in = '0;
                        end
                        for (int i = 0; i < ctph_pkg::TYPE_N; i++) begin
                           if (!ctph_pkg::lit_match(ctph_pkg::TYPE_LIT[i],
                                                    ctph_pkg::TYPE_LEN[i], tpos_in, lc)) begin
                              tmask_in[i] = 1'b0;
                           end
                        end
                        if (tpos_in < ctph_pkg::TYPE_POS_CAP) begin
                           tpos_in = tpos_in + 1'b1;
                        end
                     end
                  end
                  ctph_pkg::PH_KEY: begin
                     if (c == ctph_pkg::CH_SEMI) begin
                        phase_in = ctph_pkg::PH_STOP;
                     end else if (c == ctph_pkg::CH_EQUAL) begin
                        target_in = ctph_pkg::TGT_NONE;
                        if (kmask_in[0] &&
                            ctph_pkg::TYPE_POS_W'(kpos_in) == ctph_pkg::KEY_LEN[0]) begin
                           target_in = ctph_pkg::TGT_CHARSET;
                           cs_len_in = '0;
                        end else if (kmask_in[1] &&
                                     ctph_pkg::TYPE_POS_W'(kpos_in) == ctph_pkg::KEY_LEN[1]) begin
                           target_in = ctph_pkg::TGT_BOUNDARY;
                           bd_len_in = '0;
                        end
                        wp_in    = '0;
                        phase_in = ctph_pkg::PH_VALUE;
                     end else if (blank) begin
                        if (kpos_in != '0) begin
                           kgap_in = 1'b1;
                        end
                     end else begin
                        if (kgap_in) begin
                           kmask_in = '0;
                        end
                        for (int i = 0; i < ctph_pkg::KEY_N; i++) begin
                           if (!ctph_pkg::lit_match(ctph_pkg::KEY_LIT[i], ctph_pkg::KEY_LEN[i],
                                                    ctph_pkg::TYPE_POS_W'(kpos_in), lc)) begin
                              kmask_in[i] = 1'b0;
                           end
                        end
                        if (kpos_in < ctph_pkg::KEY_POS_CAP) begin
                           kpos_in = kpos_in + 1'b1;
                        end
                     end
                  end
                  ctph_pkg::PH_VALUE: begin
                     if (c == ctph_pkg::CH_SEMI) begin
                        target_in = ctph_pkg::TGT_NONE;
                        phase_in  = ctph_pkg::PH_KEY;
                        kmask_in  = '1;
                        kpos_in   = '0;
                        kgap_in   = 1'b0;
                     end else if (target_in != ctph_pkg::TGT_NONE &&
                                  !(blank && wp_in == '0)) begin
                        // leading blanks skipped, trailing blanks stored but not counted
                        if (wp_in < DEPTH_LEN) begin
                           wr_addr = ctph_pkg::VD_AW'(wp_in);
                           wp_in   = wp_in + 1'b1;
                           if (target_in == ctph_pkg::TGT_CHARSET) begin
                              cs_wr_en = 1'b1;
                              wr_data  = lc;
                              if (!blank) begin
                                 cs_len_in = wp_in;
                              end
                           end else begin
                              bd_wr_en = 1'b1;
                              if (!blank) begin
                                 bd_len_in = wp_in;
                              end
                           end
                        end else if (!blank) begin
                           trunc_in = 1'b1;
                           if (target_in == ctph_pkg::TGT_CHARSET) begin
                              cs_len_in = DEPTH_LEN;
                           end else begin
                              bd_len_in = DEPTH_LEN;
                           end
                        end
                     end
                  end
                  default: begin
                  end
               endcase
            end
            ctph_pkg::MODE_READ_CHARSET: begin
               cs_rd_en = 1'b1;
               if (idx_cmp < ctph_pkg::CMP_W'(cs_len_ff) && idx_cmp < DEPTH_CMP) begin
                  rd_sel_in = ctph_pkg::TGT_CHARSET;
               end
            end
            ctph_pkg::MODE_READ_BOUNDARY: begin
               bd_rd_en = 1'b1;
               if (idx_cmp < ctph_pkg::CMP_W'(bd_len_ff) && idx_cmp < DEPTH_CMP) begin
                  rd_sel_in = ctph_pkg::TGT_BOUNDARY;
               end
            end
            default: begin
            end
         endcase
      end

      type_code_in = ctph_pkg::type_class(tmask_in, tpos_in);
      rsp_valid_in = req_fire ? 1'b1 : (rsp_bus.ready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= ctph_pkg::PH_TYPE;
         tmask_ff     <= '1;
         tpos_ff      <= '0;
         tgap_ff      <= 1'b0;
         kmask_ff     <= '1;
         kpos_ff      <= '0;
         kgap_ff      <= 1'b0;
         target_ff    <= ctph_pkg::TGT_NONE;
         wp_ff        <= '0;
         cs_len_ff    <= '0;
         bd_len_ff    <= '0;
         trunc_ff     <= 1'b0;
         hstart_ff    <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         tmask_ff     <= tmask_in;
         tpos_ff      <= tpos_in;
         tgap_ff      <= tgap_in;
         kmask_ff     <= kmask_in;
         kpos_ff      <= kpos_in;
         kgap_ff      <= kgap_in;
         target_ff    <= target_in;
         wp_ff        <= wp_in;
         cs_len_ff    <= cs_len_in;
         bd_len_ff    <= bd_len_in;
         trunc_ff     <= trunc_in;
         hstart_ff    <= hstart_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // result payload, loaded with each accepted word
   always_ff @(posedge clock) begin
      if (req_fire) begin
         rd_sel_ff    <= rd_sel_in;
         type_code_ff <= type_code_in;
         done_ff      <= done_in;
      end
   end

   ctph_ram #(
      .WIDTH (8),
      .DEPTH (ctph_pkg::VALUE_DEPTH)
   ) u_charset_ram (
      .clock   (clock),
      .wr_en   (cs_wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (cs_rd_en),
      .rd_addr (rd_addr),
      .rd_data (cs_q)
   );

   ctph_ram #(
      .WIDTH (8),
      .DEPTH (ctph_pkg::VALUE_DEPTH)
   ) u_boundary_ram (
      .clock   (clock),
      .wr_en   (bd_wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (bd_rd_en),
      .rd_addr (rd_addr),
      .rd_data (bd_q)
   );

   // counts and flag reflect the state after the word, which the state registers now hold
   assign rsp_bus.valid           = rsp_valid_ff;
   assign rsp_bus.read_byte       = (rd_sel_ff == ctph_pkg::TGT_CHARSET)  ? cs_q :
                                    (rd_sel_ff == ctph_pkg::TGT_BOUNDARY) ? bd_q : 8'h00;
   assign rsp_bus.type_code       = type_code_ff;
   assign rsp_bus.charset_count   = ctph_pkg::CNT_W'(cs_len_ff);
   assign rsp_bus.boundary_count  = ctph_pkg::CNT_W'(bd_len_ff);
   assign rsp_bus.value_truncated = trunc_ff;
   assign rsp_bus.header_done     = done_ff;

   assign in_stop = (phase_ff == ctph_pkg::PH_STOP);

   `CTHP_ASSERT_IMPL(a_wp_bound, clock, reset, 1'b1, wp_ff <= DEPTH_LEN)
   `CTHP_ASSERT_IMPL(a_cs_len_wp, clock, reset, target_ff == ctph_pkg::TGT_CHARSET, cs_len_ff <= wp_ff)
   `CTHP_ASSERT_IMPL(a_bd_len_wp, clock, reset, target_ff == ctph_pkg::TGT_BOUNDARY, bd_len_ff <= wp_ff)
   `CTHP_ASSERT_NEXT(a_stop_holds, clock, reset, in_stop && !hstart_ff, in_stop)

endmodule
